[hw/rtl/deq_pkg.sv]
`default_nettype none

package deq_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IN_W     = 32;
    localparam int unsigned OUT_W    = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK       = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // one control word per chain, broadcast to every cell
    typedef struct packed {
        logic              shr;
        logic              shl;
        logic              wr_tail;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue_core.sv]
`default_nettype none

// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready tdata value, tuser cmd
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata front, back, count, empty, status
//
// one transaction per cycle in unless output stalls; one registered result per transaction
// two rows of cells: one front-aligned, one back-aligned; both ends are cell 0
// each operation is a shift or a tail write decided locally in every cell
// synchronous active-low reset clears count and output valid, not the cells
// a stalled output holds its result; input is taken while output is free or taken

module double_ended_queue_core #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire  [deq_pkg::IN_W-1:0]    i_s_axis_tdata,  // value[31:0]
    input  wire  [deq_pkg::CMD_W-1:0]   i_s_axis_tuser,  // cmd[2:0]
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    output logic [deq_pkg::OUT_W-1:0]   o_m_axis_tdata   // front[31:0], back[63:32],
                                                         // count[70:64], is_empty[71],
                                                         // status[73:72], zero[79:74]
);
    import deq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_valid;
    logic [DATA_W-1:0]   r_front;
    logic [DATA_W-1:0]   r_back;
    logic [COUNT_W-1:0]  r_count_out;
    logic                r_empty;
    t_status             r_status;

    t_cell_ctl           ctl_f;
    t_cell_ctl           ctl_b;
    t_status             status;
    logic                accept;
    logic                full;
    logic                empty;
    t_cmd                cmd;
    logic [CW+COUNT_W-1:0] count_ext;

    logic [DATA_W-1:0] f_data [DEPTH];
    logic [DATA_W-1:0] f_next [DEPTH];
    logic [DATA_W-1:0] b_data [DEPTH];
    logic [DATA_W-1:0] b_next [DEPTH];

    assign o_s_axis_tready = i_rst_n && (!r_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count == CW'(DEPTH));
    assign empty           = (r_count == '0);
    assign cmd             = t_cmd'(i_s_axis_tuser);

    always_comb begin
        ctl_f       = '0;
        ctl_b       = '0;
        ctl_f.value = i_s_axis_tdata;
        ctl_b.value = i_s_axis_tdata;
        status      = ST_OK;
        n_count     = r_count;
        unique case (cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctl_f.shr     = accept;
                    ctl_b.wr_tail = accept;
                    n_count       = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctl_b.shr     = accept;
                    ctl_f.wr_tail = accept;
                    n_count       = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctl_f.shl = accept;
                    n_count   = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctl_b.shl = accept;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cells
            logic [DATA_W-1:0] f_left, f_right, b_left, b_right;
            if (g == 0) begin : g_first
                assign f_left = i_s_axis_tdata;
                assign b_left = i_s_axis_tdata;
            end else begin : g_mid
                assign f_left = f_data[g-1];
                assign b_left = b_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign f_right = f_data[g];
                assign b_right = b_data[g];
            end else begin : g_inner
                assign f_right = f_data[g+1];
                assign b_right = b_data[g+1];
            end

            deq_cell #(.INDEX(g), .CW(CW)) u_front_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl_f),
                .i_count (r_count),
                .i_left  (f_left),
                .i_right (f_right),
                .o_data  (f_data[g]),
                .o_next  (f_next[g])
            );

            deq_cell #(.INDEX(g), .CW(CW)) u_back_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl_b),
                .i_count (r_count),
                .i_left  (b_left),
                .i_right (b_right),
                .o_data  (b_data[g]),
                .o_next  (b_next[g])
            );
        end
    endgenerate

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_front     <= (n_count == '0) ? '0 : f_next[0];
            r_back      <= (n_count == '0) ? '0 : b_next[0];
            r_count_out <= count_ext[COUNT_W-1:0];
            r_empty     <= (n_count == '0);
            r_status    <= status;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {6'd0, r_status, r_empty, r_count_out, r_back, r_front};

endmodule

`default_nettype wire

[hw/rtl/deq_cell.sv]
`default_nettype none

module deq_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 7
) (
    input  wire                        i_clk,
    input  wire  deq_pkg::t_cell_ctl   i_ctl,
    input  wire  [CW-1:0]              i_count,
    input  wire  [deq_pkg::DATA_W-1:0] i_left,
    input  wire  [deq_pkg::DATA_W-1:0] i_right,
    output logic [deq_pkg::DATA_W-1:0] o_data,
    output logic [deq_pkg::DATA_W-1:0] o_next
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shr) begin
            n_data = (INDEX == 0) ? i_ctl.value : i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end else if (i_ctl.wr_tail && (i_count == CW'(INDEX))) begin
            n_data = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

`default_nettype wire
